>>> design/assert_macros.svh
// Assertion macros for the noise unit's top-level RTL file.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define GN2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define GN2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/gn2_pkg.sv
// Shared constants, command codes and the gradient select for the noise unit.
// Depends on nothing.
package gn2_pkg;

  localparam int TABLE_ENTRIES   = 256;
  localparam int COORD_FRAC_BITS = 8;
  localparam int OUT_FRAC_BITS   = 14;

  // Internal values carry 16 fraction bits; VW covers the largest gradient sum.
  localparam int VW    = 20;
  localparam int FW    = 17;
  localparam int ONE16 = 65536;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  // Dot product of one of 16 gradients with the corner offset.
  function automatic logic signed [VW-1:0] corner_grad(input logic [3:0] h,
                                                       input logic signed [VW-1:0] dx,
                                                       input logic signed [VW-1:0] dy);
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] v;
    u = (h < 4'd8) ? dx : dy;
    if (h < 4'd4) begin
      v = dy;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = dx;
    end else begin
      v = '0;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

>>> design/gradient_noise_2d_unit.sv
// Improved 2D gradient noise unit, top level.
// Depends on gn2_pkg, gn2_ram, gn2_fade, gn2_blend and assert_macros.svh.
//
// Usage: the input channel (in_valid/in_ready) carries two kinds of transaction.
// A load (in_command = load) writes in_table_value into permutation table
// entry in_table_index and gives no result; indices past the table are ignored.
// An evaluate (in_command = evaluate) takes unsigned fixed-point coordinates
// in_coord_x/in_coord_y and produces one out_noise_value transaction, signed
// Q2.OUT_FRAC_BITS, saturated to 16 bits. Results leave in order of arrival.
// The whole table must be loaded before the first evaluate.
//
// Throughput: one transaction per cycle while in_ready is high. An evaluate's
// result passes through two table read stages, the fade multiplier chain,
// two interpolation levels and the output register before it shows on
// out_valid. The table is three RAM copies with two read ports each,
// written in pipeline order so loads and evaluates never overtake each other.
//
// Reset (rst_n low, synchronous) empties the pipeline and output register; the
// table keeps its contents and needs no clearing pass. When the receiver holds
// out_ready low, the pipeline keeps accepting until an evaluate reaches its
// last stage with the output register still full; then in_ready drops.
`include "assert_macros.svh"

module gradient_noise_2d_unit #(
  parameter int TABLE_ENTRIES   = gn2_pkg::TABLE_ENTRIES,
  parameter int COORD_FRAC_BITS = gn2_pkg::COORD_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = gn2_pkg::OUT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  input  logic [15:0]        in_coord_x,
  input  logic [15:0]        in_coord_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_noise_value
);

  localparam int VW   = gn2_pkg::VW;
  localparam int FW   = gn2_pkg::FW;
  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int NS   = 8;
  localparam int RECIP = ((1 << 24) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
  localparam int SHL  = (OUT_FRAC_BITS >= 16) ? OUT_FRAC_BITS - 16 : 0;
  localparam int SHR  = (OUT_FRAC_BITS < 16) ? 16 - OUT_FRAC_BITS : 0;
  localparam int SW   = VW + SHL;
  localparam logic [31:0] FMASK = (32'd1 << COORD_FRAC_BITS) - 32'd1;

  // Table address wrap: reciprocal multiply, then one correcting subtract.
  function automatic logic [AW-1:0] wrap_addr(input logic [9:0] v);
    logic [34:0] prod;
    logic [9:0]  q;
    logic [9:0]  rem;
    prod = 35'(v) * 35'(RECIP);
    q    = 10'(prod >> 24);
    rem  = v - 10'(q * 10'(TABLE_ENTRIES));
    if (rem >= 10'(TABLE_ENTRIES)) begin
      rem = rem - 10'(TABLE_ENTRIES);
    end
    return AW'(rem);
  endfunction

  logic en;
  logic in_acc;
  logic [NS:1] ev_r;

  // Input decode.
  logic [31:0] cx32;
  logic [31:0] cy32;
  logic [7:0]  ix;
  logic [7:0]  iy;
  logic [15:0] xf;
  logic [15:0] yf;
  logic        load_ok;

  assign cx32 = 32'(in_coord_x);
  assign cy32 = 32'(in_coord_y);
  assign ix   = 8'(cx32 >> COORD_FRAC_BITS);
  assign iy   = 8'(cy32 >> COORD_FRAC_BITS);
  assign xf   = 16'((cx32 & FMASK) << (16 - COORD_FRAC_BITS));
  assign yf   = 16'((cy32 & FMASK) << (16 - COORD_FRAC_BITS));

  assign en      = !(ev_r[NS] && out_valid && !out_ready);
  assign in_ready = en;
  assign in_acc  = in_valid && in_ready;
  assign load_ok = (9'(in_table_index) < 9'(TABLE_ENTRIES));

  // Stage 1 registers.
  logic          s1_load_r;
  logic [AW-1:0] s1_idx_r;
  logic [7:0]    s1_val_r;
  logic [7:0]    s1_iy_r;
  logic [15:0]   s1_xf_r;
  logic [15:0]   s1_yf_r;
  logic [7:0]    pa;
  logic [7:0]    pb;

  gn2_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram_a (
    .clk       (clk),
    .wr_en     (in_acc && in_command == gn2_pkg::CMD_LOAD && load_ok),
    .wr_addr   (in_table_index[AW-1:0]),
    .wr_data   (in_table_value),
    .rd_en     (en),
    .rd_addr_a (wrap_addr(10'(ix))),
    .rd_addr_b (wrap_addr(10'(ix) + 10'd1)),
    .rd_data_a (pa),
    .rd_data_b (pb)
  );

  // Stage 1: second-level hash addresses.
  logic [9:0] a_sum;
  logic [9:0] b_sum;
  logic [7:0] haa;
  logic [7:0] hab;
  logic [7:0] hba;
  logic [7:0] hbb;

  assign a_sum = 10'(pa) + 10'(s1_iy_r);
  assign b_sum = 10'(pb) + 10'(s1_iy_r);

  gn2_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram_b0 (
    .clk       (clk),
    .wr_en     (en && s1_load_r),
    .wr_addr   (s1_idx_r),
    .wr_data   (s1_val_r),
    .rd_en     (en),
    .rd_addr_a (wrap_addr(a_sum)),
    .rd_addr_b (wrap_addr(a_sum + 10'd1)),
    .rd_data_a (haa),
    .rd_data_b (hab)
  );

  gn2_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_ram_b1 (
    .clk       (clk),
    .wr_en     (en && s1_load_r),
    .wr_addr   (s1_idx_r),
    .wr_data   (s1_val_r),
    .rd_en     (en),
    .rd_addr_a (wrap_addr(b_sum)),
    .rd_addr_b (wrap_addr(b_sum + 10'd1)),
    .rd_data_a (hba),
    .rd_data_b (hbb)
  );

  // Fade weights leave their units aligned with stage 4.
  logic [FW-1:0] wu;
  logic [FW-1:0] wv;

  gn2_fade u_fade_x (.clk(clk), .en(en), .t(s1_xf_r), .fade(wu));
  gn2_fade u_fade_y (.clk(clk), .en(en), .t(s1_yf_r), .fade(wv));

  // Stage 2: corner gradients.
  logic [15:0] s2_xf_r;
  logic [15:0] s2_yf_r;
  logic signed [VW-1:0] dx0;
  logic signed [VW-1:0] dy0;
  logic signed [VW-1:0] dx1;
  logic signed [VW-1:0] dy1;
  logic signed [VW-1:0] g_aa_r [3:4];
  logic signed [VW-1:0] g_ab_r [3:4];
  logic signed [VW-1:0] g_ba_r [3:4];
  logic signed [VW-1:0] g_bb_r [3:4];

  assign dx0 = VW'(s2_xf_r);
  assign dy0 = VW'(s2_yf_r);
  assign dx1 = dx0 - VW'(gn2_pkg::ONE16);
  assign dy1 = dy0 - VW'(gn2_pkg::ONE16);

  // Stages 4 to 8: two interpolation levels.
  logic signed [VW-1:0] lo;
  logic signed [VW-1:0] hi;
  logic signed [VW-1:0] r;
  logic [FW-1:0]        wv_r [5:6];

  gn2_blend u_blend_lo (
    .clk(clk), .en(en), .w(wu), .a(g_aa_r[4]), .b(g_ba_r[4]), .y(lo)
  );
  gn2_blend u_blend_hi (
    .clk(clk), .en(en), .w(wu), .a(g_ab_r[4]), .b(g_bb_r[4]), .y(hi)
  );
  gn2_blend u_blend_y (
    .clk(clk), .en(en), .w(wv_r[6]), .a(lo), .b(hi), .y(r)
  );

  // Output scaling, floor on narrowing, and saturation.
  logic signed [SW-1:0] scaled;
  logic signed [15:0]   sat_nxt;
  logic signed [15:0]   out_noise_value_r;
  logic                 out_valid_r;

  assign scaled = (SW'(r) <<< SHL) >>> SHR;

  always_comb begin
    if (scaled > SW'(32767)) begin
      sat_nxt = 16'sh7FFF;
    end else if (scaled < SW'(-32768)) begin
      sat_nxt = -16'sh8000;
    end else begin
      sat_nxt = 16'(scaled);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx_r  <= in_table_index[AW-1:0];
      s1_val_r  <= in_table_value;
      s1_iy_r   <= iy;
      s1_xf_r   <= xf;
      s1_yf_r   <= yf;
      s2_xf_r   <= s1_xf_r;
      s2_yf_r   <= s1_yf_r;
      g_aa_r[3] <= gn2_pkg::corner_grad(haa[3:0], dx0, dy0);
      g_ba_r[3] <= gn2_pkg::corner_grad(hba[3:0], dx1, dy0);
      g_ab_r[3] <= gn2_pkg::corner_grad(hab[3:0], dx0, dy1);
      g_bb_r[3] <= gn2_pkg::corner_grad(hbb[3:0], dx1, dy1);
      g_aa_r[4] <= g_aa_r[3];
      g_ba_r[4] <= g_ba_r[3];
      g_ab_r[4] <= g_ab_r[3];
      g_bb_r[4] <= g_bb_r[3];
      wv_r[5]   <= wv;
      wv_r[6]   <= wv_r[5];
    end
    if (en && ev_r[NS]) begin
      out_noise_value_r <= sat_nxt;
    end
  end

  // Control registers: valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r        <= '0;
      s1_load_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        ev_r      <= {ev_r[NS-1:1], in_acc && in_command == gn2_pkg::CMD_EVAL};
        s1_load_r <= in_acc && in_command == gn2_pkg::CMD_LOAD && load_ok;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (en && ev_r[NS]) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

  // The input side only stalls behind a full output register.
  `GN2_ASSERT(a_stall_cause, !in_ready |-> (out_valid && !out_ready), "in_ready low without output stall")
  // A finished evaluate that moves on always lands in the output register.
  `GN2_ASSERT(a_last_lands, (ev_r[NS] && en) |=> out_valid, "result lost at last stage")
  // A stage-one slot holds a load or an evaluate, never both.
  `GN2_ASSERT(a_s1_excl, !(s1_load_r && ev_r[1]), "load and evaluate share stage one")
  // A ready receiver never blocks the input.
  `GN2_ASSERT(a_ready_flow, out_ready |-> in_ready, "in_ready low while receiver ready")

endmodule

>>> design/gn2_ram.sv
// Generic RAM: one write port, two registered read ports.
// Depends on nothing.
module gn2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> design/gn2_fade.sv
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 on a 16-bit fraction.
// Depends on gn2_pkg.
module gn2_fade (
  input  logic                     clk,
  input  logic                     en,
  input  logic [15:0]              t,
  output logic [gn2_pkg::FW-1:0]   fade
);

  logic [19:0] n1;
  logic [35:0] m1_r;
  logic [31:0] m2_r;
  logic [15:0] t_r;
  logic [19:0] s2_nxt;
  logic [15:0] t3_nxt;
  logic [31:0] t3_prod;
  logic [19:0] s2_r;
  logic [15:0] t3_r;
  logic [35:0] f_prod;
  logic [gn2_pkg::FW-1:0] fade_r;

  assign n1      = 20'(983040) - 20'(20'(t) * 20'd6);
  assign s2_nxt  = 20'(655360) - 20'(m1_r >> 16);
  assign t3_prod = 32'(m2_r[31:16]) * 32'(t_r);
  assign t3_nxt  = t3_prod[31:16];
  assign f_prod  = 36'(t3_r) * 36'(s2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= 36'(t) * 36'(n1);
      m2_r   <= 32'(t) * 32'(t);
      t_r    <= t;
      s2_r   <= s2_nxt;
      t3_r   <= t3_nxt;
      fade_r <= gn2_pkg::FW'(f_prod >> 16);
    end
  end

  assign fade = fade_r;

endmodule

>>> design/gn2_blend.sv
// Two-stage linear interpolation a + floor(w * (b - a) / 2^16).
// Depends on gn2_pkg.
module gn2_blend (
  input  logic                            clk,
  input  logic                            en,
  input  logic [gn2_pkg::FW-1:0]          w,
  input  logic signed [gn2_pkg::VW-1:0]   a,
  input  logic signed [gn2_pkg::VW-1:0]   b,
  output logic signed [gn2_pkg::VW-1:0]   y
);

  localparam int PW = gn2_pkg::VW + 1 + gn2_pkg::FW + 1;

  logic signed [gn2_pkg::VW:0]   diff;
  logic signed [gn2_pkg::FW:0]   w_s;
  logic signed [PW-1:0]          prod_r;
  logic signed [gn2_pkg::VW-1:0] a_r;
  logic signed [gn2_pkg::VW-1:0] y_r;

  assign diff = (gn2_pkg::VW + 1)'(b) - (gn2_pkg::VW + 1)'(a);
  assign w_s  = $signed({1'b0, w});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(w_s) * PW'(diff);
      a_r    <= a;
      y_r    <= a_r + gn2_pkg::VW'(prod_r >>> 16);
    end
  end

  assign y = y_r;

endmodule

>>> tb/sv/gradient_noise_2d_unit_tb.sv
// Self-checking testbench for the 2D gradient noise unit: loads the permutation
// table, evaluates noise samples and compares each result with a local predictor.
// Depends on gn2_pkg and the gradient_noise_2d_unit RTL.
`timescale 1ns / 1ps

module gradient_noise_2d_unit_tb;

  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    gn2_pkg::cmd_t command;
    logic [7:0]    table_index;
    logic [7:0]    table_value;
    logic [15:0]   coord_x;
    logic [15:0]   coord_y;
  } noise_req_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_command;
  logic [7:0]         in_table_index;
  logic [7:0]         in_table_value;
  logic [15:0]        in_coord_x;
  logic [15:0]        in_coord_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_noise_value;

  gradient_noise_2d_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_table_index(in_table_index),
    .in_table_value(in_table_value), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_noise_value(out_noise_value)
  );

  // Pending stimulus, the predictor's own copy of the permutation table, and the
  // noise samples still owed by the block, oldest first.
  noise_req_t         pending_reqs[$];
  logic [7:0]         perm_copy[256];
  logic signed [15:0] owed_noise[$];
  int                 mismatches;
  int                 cycle_count;
  bit                 stim_done;
  bit                 steady_phase;   // When set, neither side idles.
  bit                 in_fire;        // The last rising edge accepted an input.

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Quintic fade at 16 fraction bits; every intermediate stays non-negative.
  function automatic longint fade_weight(input longint t);
    longint n1, s2, t3;
    n1 = 15 * 65536 - 6 * t;
    s2 = 10 * 65536 - ((t * n1) >>> 16);
    t3 = (((t * t) >>> 16) * t) >>> 16;
    return (t3 * s2) >>> 16;
  endfunction

  function automatic longint grad_dot(input logic [3:0] h, input longint dx,
                                      input longint dy);
    longint u, v;
    u = (h < 8) ? dx : dy;
    if (h < 4) v = dy;
    else if (h == 12 || h == 14) v = dx;
    else v = 0;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // Arithmetic shift of a signed longint rounds toward minus infinity.
  function automatic longint lerp16(input longint w, input longint a, input longint b);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic logic signed [15:0] predict_noise(input logic [15:0] cx,
                                                       input logic [15:0] cy);
    logic [7:0] ix, iy, a, b;
    logic [7:0] haa, hab, hba, hbb;
    longint xf, yf, wu, wv, lo, hi, r;
    ix = cx[15:8];
    iy = cy[15:8];
    xf = longint'(cx[7:0]) << 8;
    yf = longint'(cy[7:0]) << 8;
    wu = fade_weight(xf);
    wv = fade_weight(yf);
    a = perm_copy[ix] + iy;
    b = perm_copy[8'(ix + 8'd1)] + iy;
    haa = perm_copy[a];
    hab = perm_copy[8'(a + 8'd1)];
    hba = perm_copy[b];
    hbb = perm_copy[8'(b + 8'd1)];
    lo = lerp16(wu, grad_dot(haa[3:0], xf, yf), grad_dot(hba[3:0], xf - 65536, yf));
    hi = lerp16(wu, grad_dot(hab[3:0], xf, yf - 65536),
                grad_dot(hbb[3:0], xf - 65536, yf - 65536));
    r = lerp16(wv, lo, hi) >>> 2;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic noise_req_t make_load(input logic [7:0] idx, input logic [7:0] val);
    noise_req_t req;
    req.command = gn2_pkg::CMD_LOAD;
    req.table_index = idx;
    req.table_value = val;
    req.coord_x = 16'($urandom);
    req.coord_y = 16'($urandom);
    return req;
  endfunction

  function automatic noise_req_t make_eval(input logic [15:0] x, input logic [15:0] y);
    noise_req_t req;
    req.command = gn2_pkg::CMD_EVAL;
    req.table_index = 8'($urandom);
    req.table_value = 8'($urandom);
    req.coord_x = x;
    req.coord_y = y;
    return req;
  endfunction

  // Appends one transaction at the tail of the stimulus queue.
  function automatic void queue_req(input noise_req_t req);
    pending_reqs.insert(pending_reqs.size(), req);
  endfunction

  // Driver: inputs change on the falling edge. A transaction leaves only after
  // the previous rising edge saw valid and ready together.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_reqs.size() > 0 && (steady_phase || $urandom_range(99) >= 32)) begin
        noise_req_t req;
        req = pending_reqs.pop_front();
        in_valid       <= 1'b1;
        in_command     <= req.command;
        in_table_index <= req.table_index;
        in_table_value <= req.table_value;
        in_coord_x     <= req.coord_x;
        in_coord_y     <= req.coord_y;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady_phase || ($urandom_range(99) >= 32);
  end

  // Monitor: accepted input transactions update the predictor; accepted result
  // transactions are checked against the oldest owed sample.
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (in_valid && in_ready) begin
        if (in_command == gn2_pkg::CMD_LOAD) perm_copy[in_table_index] = in_table_value;
        else owed_noise.insert(owed_noise.size(), predict_noise(in_coord_x, in_coord_y));
      end
      if (out_valid && out_ready) begin
        if (owed_noise.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected noise transaction: got %0d", out_noise_value);
        end else begin
          logic signed [15:0] want;
          want = owed_noise.pop_front();
          if (want !== out_noise_value) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("noise mismatch: expected %0d, got %0d", want, out_noise_value);
          end
        end
      end
    end
  end

  // Whole table reload with random bytes, in shuffled index order.
  task automatic queue_table_fill();
    int order[256];
    foreach (order[i]) order[i] = i;
    order.shuffle();
    foreach (order[i]) queue_req(make_load(8'(order[i]), 8'($urandom)));
  endtask

  // Stimulus plan, then the end-of-run check.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = gn2_pkg::CMD_LOAD;
    in_table_index = '0;
    in_table_value = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    out_ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    stim_done = 1'b0;
    steady_phase = 1'b0;
    in_fire = 1'b0;
    foreach (perm_copy[i]) perm_copy[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // The table must be complete before any evaluate.
    queue_table_fill();
    // Directed: coordinate extremes, lattice wrap and integer corners.
    queue_req(make_eval(16'h0000, 16'h0000));
    queue_req(make_eval(16'hFFFF, 16'hFFFF));
    queue_req(make_eval(16'hFFFF, 16'h0000));
    queue_req(make_eval(16'h0000, 16'hFFFF));
    queue_req(make_eval(16'h0080, 16'h0080));
    queue_req(make_eval(16'hFF80, 16'h00FF));
    queue_req(make_eval(16'h0100, 16'hFF00));
    queue_req(make_eval(16'h5501, 16'hAAFE));
    // Loads with extreme indices and values between evaluates, mostly
    // rewriting entries so every gradient code gets exercised.
    queue_req(make_load(8'hFF, 8'hFF));
    queue_req(make_load(8'h00, 8'h00));
    queue_req(make_eval(16'hFF40, 16'h7FC0));
    queue_req(make_eval(16'h00C0, 16'h0040));
    for (int h = 0; h < 16; h++) queue_req(make_load(8'(h), 8'(h * 17)));
    queue_req(make_eval(16'h0333, 16'h02CC));

    // Random part: mostly evaluates with loads mixed in, and one full reload.
    for (int n = 0; n < 1200; n++) begin
      if (n == 600) queue_table_fill();
      if ($urandom_range(99) < 20) queue_req(make_load(8'($urandom), 8'($urandom)));
      else queue_req(make_eval(16'($urandom), 16'($urandom)));
    end

    fork
      begin
        // Long stretch with no idling in the middle of the run.
        wait (pending_reqs.size() < 900);
        steady_phase = 1'b1;
        wait (pending_reqs.size() < 600);
        steady_phase = 1'b0;
        wait (pending_reqs.size() == 0);
        @(posedge clk);
        while (in_valid) @(posedge clk);
        wait (owed_noise.size() == 0);
        repeat (20) @(posedge clk);
        stim_done = 1'b1;
      end
      wait (cycle_count >= MAX_CYCLES);
    join_any

    if (!stim_done) begin
      $display("gradient_noise_2d_unit_tb: FAIL");
    end else if (mismatches == 0 && owed_noise.size() == 0) begin
      $display("gradient_noise_2d_unit_tb: PASS");
    end else begin
      $display("gradient_noise_2d_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
